/* hdl/h263dp_pkg.sv */
// Shared types and constants for the H.263 RTP payload depacketizer.
// No dependencies; imported by every module of the block.
package h263dp_pkg;

    localparam int POS_W = 7;
    localparam logic [POS_W-1:0] POS_MAX = 7'd127;
    localparam logic [POS_W-1:0] HDR_BASE = 7'd2;

    // Bits of header byte 0
    localparam int P_BIT = 2;
    localparam int V_BIT = 1;
    localparam int PLEN_HI_BIT = 0;

    // Number of results queued by one input byte
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       short_packet;
        logic       run_last;
    } res_t;

    // Results produced by one accepted input byte
    typedef struct packed {
        res_t       r0;
        res_t       r1;
        logic [1:0] count;
    } push_t;

endpackage

/* hdl/h263dp_parser.sv */
// Payload header parser: tracks position in the packet and forms the results
// of one input byte. Depends on h263dp_pkg.
module h263dp_parser
    import h263dp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] payload_byte,
    input  logic       packet_last,
    input  logic       rtp_marker,
    output push_t      push
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] hlen_reg, hlen_next;
    logic             pflag_reg, pflag_next;
    logic             vflag_reg, vflag_next;
    logic             phigh_reg, phigh_next;

    logic             pos0;
    logic             pos1;
    logic             eff_p;
    logic             eff_v;
    logic             eff_ph;
    logic [POS_W-1:0] hlen_eff;
    logic [POS_W:0]   pos_inc;
    logic             is_data;
    logic             hdr_end;
    logic             is_short;
    res_t             r_data;
    res_t             r_zero;
    res_t             r_flag;

    // Header fields: byte 0 takes the flags live, byte 1 completes PLEN
    always_comb
    begin
        pos0   = (pos_reg == '0);
        pos1   = (pos_reg == POS_W'(1));
        eff_p  = pos0 ? payload_byte[P_BIT]       : pflag_reg;
        eff_v  = pos0 ? payload_byte[V_BIT]       : vflag_reg;
        eff_ph = pos0 ? payload_byte[PLEN_HI_BIT] : phigh_reg;
        if (pos0)
        begin
            hlen_eff = HDR_BASE + POS_W'(payload_byte[V_BIT]);
        end
        else if (pos1)
        begin
            hlen_eff = HDR_BASE + POS_W'(vflag_reg)
                     + POS_W'({phigh_reg, payload_byte[7:3]});
        end
        else
        begin
            hlen_eff = hlen_reg;
        end
        pos_inc  = {1'b0, pos_reg} + (POS_W+1)'(1);
        is_data  = (pos_reg >= hlen_eff);
        hdr_end  = (pos_inc == {1'b0, hlen_eff}) && eff_p;
        is_short = (pos_inc < {1'b0, hlen_eff});
    end

    // Result forming
    always_comb
    begin
        r_data = '{out_byte: payload_byte, byte_valid: 1'b1,
                   frame_end: packet_last & rtp_marker, short_packet: 1'b0,
                   run_last: 1'b1};
        r_zero = '{out_byte: 8'h00, byte_valid: 1'b1, frame_end: 1'b0,
                   short_packet: 1'b0, run_last: 1'b0};
        r_flag = '{out_byte: 8'h00, byte_valid: 1'b0, frame_end: rtp_marker,
                   short_packet: is_short, run_last: 1'b1};
        push.r0    = r_data;
        push.r1    = r_zero;
        push.count = CNT_NONE;
        if (is_data)
        begin
            push.count = CNT_ONE;
        end
        else if (hdr_end)
        begin
            push.r0           = r_zero;
            push.r1           = r_zero;
            push.r1.frame_end = packet_last & rtp_marker;
            push.r1.run_last  = 1'b1;
            push.count        = CNT_TWO;
        end
        else if (packet_last && (is_short || rtp_marker))
        begin
            push.r0    = r_flag;
            push.count = CNT_ONE;
        end
    end

    // Next state: packet end returns to the start-of-packet values
    always_comb
    begin
        if (packet_last)
        begin
            pos_next   = '0;
            hlen_next  = HDR_BASE;
            pflag_next = 1'b0;
            vflag_next = 1'b0;
            phigh_next = 1'b0;
        end
        else
        begin
            pos_next   = (pos_reg == POS_MAX) ? pos_reg : pos_inc[POS_W-1:0];
            hlen_next  = hlen_eff;
            pflag_next = eff_p;
            vflag_next = eff_v;
            phigh_next = eff_ph;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hlen_reg  <= HDR_BASE;
            pflag_reg <= 1'b0;
            vflag_reg <= 1'b0;
            phigh_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            hlen_reg  <= hlen_next;
            pflag_reg <= pflag_next;
            vflag_reg <= vflag_next;
            phigh_reg <= phigh_next;
        end
    end

endmodule

/* hdl/h263dp_out_queue.sv */
// Two-entry result register: holds the results of one input byte and
// releases them in order. Depends on h263dp_pkg.
module h263dp_out_queue
    import h263dp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_en,
    input  push_t push,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  head
);

    logic [1:0] count_reg, count_next;
    res_t       slot0_reg, slot0_next;
    res_t       slot1_reg, slot1_next;
    logic       pop;

    // A new request only lands in an empty queue (after this cycle's pop)
    assign in_ready  = (count_reg == CNT_NONE) || ((count_reg == CNT_ONE) && out_ready);
    assign out_valid = (count_reg != CNT_NONE);
    assign pop       = out_valid && out_ready;
    assign head      = slot0_reg;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push_en)
        begin
            count_next = push.count;
            slot0_next = push.r0;
            slot1_next = push.r1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_NONE;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload slots, no reset needed
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // Queue never holds more than the two results of one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue overflow");

    // The head marks end of run exactly when it is the only entry left
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && head.run_last |-> count_reg == CNT_ONE)
        else $error("run_last on head with a result still behind it");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head.run_last |-> count_reg == CNT_TWO)
        else $error("run without closing result");

    // No new byte while two results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_TWO |-> !in_ready)
        else $error("byte accepted over pending results");

endmodule

/* hdl/h263_rtp_payload_depacketizer.sv */
// A result is registered and appears on the master side in the cycle after its byte is accepted.
// One byte per cycle while m_tready is high; a byte that closes a header with P set yields two
//   zero bytes and holds the input while the second leaves.
// Header bytes that cause no result are accepted and produce nothing.
// Reset (rst_n low, asynchronous) empties the result register and returns the
//   parser to the start of a packet.
module h263_rtp_payload_depacketizer
    import h263dp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] payload_byte
    input  logic       s_tlast,   // packet_last
    input  logic [0:0] s_tuser,   // [0] rtp_marker
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic [2:0] m_tuser    // [0] byte_valid, [1] frame_end, [2] short_packet
);

    logic  accept;
    push_t push;
    res_t  head;

    assign accept = s_tvalid && s_tready;

    h263dp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .payload_byte (s_tdata),
        .packet_last  (s_tlast),
        .rtp_marker   (s_tuser[0]),
        .push         (push)
    );

    h263dp_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (push),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    assign m_tdata = head.out_byte;
    assign m_tlast = head.run_last;
    assign m_tuser = {head.short_packet, head.frame_end, head.byte_valid};

endmodule

/* bench/h263_depack_checker.sv */
// Result checker for the H.263 RTP payload depacketizer testbench.
// Watches both stream channels, predicts the bitstream from accepted payload bytes
// and compares it with what leaves the block. Depends on h263dp_pkg.
module h263_depack_checker
    import h263dp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] payload_byte
    input  logic       s_tlast,   // packet_last
    input  logic [0:0] s_tuser,   // [0] rtp_marker
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic       m_tlast,   // run_last
    input  logic [2:0] m_tuser,   // [0] byte_valid, [1] frame_end, [2] short_packet
    output int         fail_count,
    output int         pending
);

    localparam int MAX_REPORTS = 50;

    // Parser state mirrored from the payload header rules
    logic [POS_W-1:0] byte_pos;
    logic [POS_W-1:0] hdr_len;
    logic             pic_start;
    logic             vrc;
    logic             plen_hi;

    res_t bitstream_q[$];

    function automatic res_t mk_res(input logic [7:0] b, input logic valid,
                                    input logic fend, input logic shrt);
        res_t r;
        r.out_byte     = b;
        r.byte_valid   = valid;
        r.frame_end    = fend;
        r.short_packet = shrt;
        r.run_last     = 1'b0;
        return r;
    endfunction

    task automatic parser_clear();
        byte_pos  = '0;
        hdr_len   = HDR_BASE;
        pic_start = 1'b0;
        vrc       = 1'b0;
        plen_hi   = 1'b0;
    endtask

    // Work out the results of one payload byte and queue them
    task automatic depack_byte(input logic [7:0] b, input logic last,
                               input logic marker);
        res_t outs[2];
        int   n;
        int   pos;
        logic is_short;
        n   = 0;
        pos = int'(byte_pos);
        if (pos == 0)
        begin
            pic_start = b[P_BIT];
            vrc       = b[V_BIT];
            plen_hi   = b[PLEN_HI_BIT];
            hdr_len   = HDR_BASE + {6'd0, vrc};
        end
        else if (pos == 1)
        begin
            hdr_len = HDR_BASE + {6'd0, vrc} + {1'b0, plen_hi, b[7:3]};
        end

        if (pos >= int'(hdr_len))
        begin
            outs[0] = mk_res(b, 1'b1, 1'b0, 1'b0);
            n = 1;
        end
        else if (pos + 1 == int'(hdr_len) && pic_start)
        begin
            // header closes with picture start: two zero bytes go first
            outs[0] = mk_res(8'h00, 1'b1, 1'b0, 1'b0);
            outs[1] = mk_res(8'h00, 1'b1, 1'b0, 1'b0);
            n = 2;
        end

        if (last)
        begin
            is_short = (pos + 1 < int'(hdr_len));
            if (n > 0)
                outs[n-1].frame_end = marker;
            else if (is_short || marker)
            begin
                outs[0] = mk_res(8'h00, 1'b0, marker, is_short);
                n = 1;
            end
            parser_clear();
        end
        else if (byte_pos < POS_MAX)
        begin
            byte_pos = byte_pos + POS_W'(1);
        end

        if (n > 0)
            outs[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            bitstream_q.push_back(outs[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            parser_clear();
            bitstream_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // input request accepted
            if (s_tvalid && s_tready)
                depack_byte(s_tdata, s_tlast, s_tuser[0]);

            // result accepted: compare against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.out_byte     = m_tdata;
                got.byte_valid   = m_tuser[0];
                got.frame_end    = m_tuser[1];
                got.short_packet = m_tuser[2];
                got.run_last     = m_tlast;
                if (bitstream_q.size() == 0)
                begin
                    fail_count++;
                    // fields: byte/valid/fend/short/last
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result %02h/%0b/%0b/%0b/%0b",
                                 $time, got.out_byte, got.byte_valid,
                                 got.frame_end, got.short_packet, got.run_last);
                end
                else
                begin
                    want = bitstream_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        // fields: byte/valid/fend/short/last
                        if (fail_count <= MAX_REPORTS)
                            $display({"%0t: mismatch expected %02h/%0b/%0b/%0b/%0b",
                                      " got %02h/%0b/%0b/%0b/%0b"},
                                     $time, want.out_byte, want.byte_valid,
                                     want.frame_end, want.short_packet,
                                     want.run_last, got.out_byte,
                                     got.byte_valid, got.frame_end,
                                     got.short_packet, got.run_last);
                    end
                end
            end
            pending = bitstream_q.size();
        end
    end

endmodule

/* bench/h263_rtp_payload_depacketizer_tb.sv */
// Top of the H.263 RTP payload depacketizer testbench: clock, reset, packet stimulus
// and receiver back-pressure. Depends on h263dp_pkg, the block and h263_depack_checker.
module h263_rtp_payload_depacketizer_tb
    import h263dp_pkg::*;
();

    localparam int PHASE_ITEMS = 170;
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES = 20;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] payload_byte
    logic       s_tlast;   // packet_last
    logic [0:0] s_tuser;   // [0] rtp_marker
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic       m_tlast;   // run_last
    logic [2:0] m_tuser;   // [0] byte_valid, [1] frame_end, [2] short_packet

    int fail_count;
    int pending;
    int idle_pct;
    int stall_pct;
    int phase_items;
    int hold_left;
    logic hold_req;
    logic [7:0] pkt_q[$];

    h263_rtp_payload_depacketizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    h263_depack_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req && hold_left == 0)
        begin
            hold_req  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one payload byte after a random gap and wait for the request to go through
    task automatic send_byte(input logic [7:0] b, input logic last, input logic marker);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tlast    <= last;
        s_tuser[0] <= marker;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        phase_items++;
    endtask

    // Send the bytes held in pkt_q as one packet
    task automatic send_packet(input logic marker);
        for (int i = 0; i < pkt_q.size(); i++)
            send_byte(pkt_q[i], i == pkt_q.size() - 1, marker);
        pkt_q.delete();
    endtask

    // Sender pause until every predicted result has left the block
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Random packet: mostly well-formed, some short, some ending at the header, some noise
    task automatic send_random_packet(input bit force_long);
        logic [7:0] hdr0;
        logic [7:0] hdr1;
        logic [5:0] plen;
        logic       p;
        logic       v;
        int         kind;
        int         hdr;
        int         total;
        int         r;
        kind = $urandom_range(99);
        p    = 1'($urandom);
        v    = 1'($urandom);
        r    = $urandom_range(99);
        if (r < 70)
            plen = 6'($urandom_range(3));
        else if (r < 90)
            plen = 6'($urandom_range(15));
        else
            plen = 6'($urandom_range(63));
        hdr = 2 + v + plen;
        if (force_long)
            total = $urandom_range(150, 130);
        else if (kind < 75)
            total = hdr + $urandom_range(20, 1);
        else if (kind < 85)
            total = $urandom_range(hdr - 1, 1);
        else if (kind < 95)
            total = hdr;
        else
            total = $urandom_range(12, 1);

        hdr0 = 8'($urandom);
        hdr0[P_BIT] = p;
        hdr0[V_BIT] = v;
        hdr0[PLEN_HI_BIT] = plen[5];
        hdr1 = 8'($urandom);
        hdr1[7:3] = plen[4:0];
        for (int i = 0; i < total; i++)
        begin
            if (kind >= 95 && !force_long)
                pkt_q.push_back(8'($urandom));
            else if (i == 0)
                pkt_q.push_back(hdr0);
            else if (i == 1)
                pkt_q.push_back(hdr1);
            else
                pkt_q.push_back(8'($urandom));
        end
        send_packet(1'($urandom));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        hold_req  = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        phase_items = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets
        // one-byte packets: short, with and without marker
        pkt_q = '{8'hFF};                      send_packet(1'b1);
        pkt_q = '{8'h00};                      send_packet(1'b0);
        // P set, header ends on the last byte: the second zero byte carries frame end
        pkt_q = '{8'h04, 8'h00};               send_packet(1'b1);
        // P clear, header ends on the last byte, with and without marker
        pkt_q = '{8'h00, 8'h07};               send_packet(1'b1);
        pkt_q = '{8'hF8, 8'h00};               send_packet(1'b0);
        // P and V set, one VRC byte, then data at both extremes
        pkt_q = '{8'h06, 8'h07, 8'hAA, 8'h00, 8'hFF};
        send_packet(1'b1);
        // PLEN high bit set, packet ends deep inside the header
        pkt_q = '{8'hF9, 8'hFF, 8'h12};        send_packet(1'b1);
        // PLEN of one, data passes through
        pkt_q = '{8'h00, 8'h08, 8'h55, 8'h00, 8'hFF, 8'h80};
        send_packet(1'b0);
        wait_drained();

        // Random packets over the idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 51;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 51;
                end
                default:
                begin
                    idle_pct  = 32;
                    stall_pct = 32;
                end
            endcase
            // long receiver hold-off while the sender keeps going
            if (phase == 0)
                hold_req <= 1'b1;
            phase_items = 0;
            send_random_packet(phase == 1);
            while (phase_items < PHASE_ITEMS)
                send_random_packet(1'b0);
            wait_drained();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
